>>> hdl/tcpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpid_pkg: shared types and constants for the three-channel pid drive
// Field widths, register indexes, reset values and the stage records that
// travel between the pipeline modules.
// ----------------------------------------------------------------------------
package tcpid_pkg;

    // channel count default and fixed-point gain format
    localparam int CHANNELS_DEFAULT = 3;
    localparam int GAIN_FRAC_BITS   = 8;

    // field widths
    localparam int CH_W        = 2;
    localparam int ANGLE_W     = 16;
    localparam int RANGE_W     = 16;
    localparam int ILIM_W      = 24;
    localparam int GAIN_W      = 16;
    localparam int DUTY_W      = 15;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // datapath widths
    localparam int TARG_W = ANGLE_W + 1;     // clamped target
    localparam int ERR_W  = 18;              // target minus measured
    localparam int INT_W  = 25;              // integral accumulator
    localparam int ISUM_W = INT_W + 1;       // integral before clamp
    localparam int DER_W  = ERR_W + 1;       // error minus previous error
    localparam int PE_W   = GAIN_W + ERR_W;
    localparam int PI_W   = GAIN_W + INT_W;
    localparam int PD_W   = GAIN_W + DER_W;
    localparam int SUM_W  = PI_W + 2;        // holds the sum of all three products

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ANGLE_RANGE    = 3'd0,
        REG_INTEGRAL_LIMIT = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4,
        REG_DUTY_LIMIT     = 3'd5,
        REG_MOTORS_ENABLED = 3'd6
    } cfg_reg_t;

    // configuration reset values
    localparam logic [RANGE_W-1:0]        ANGLE_RANGE_RST    = 16'hFFFF;
    localparam logic [ILIM_W-1:0]         INTEGRAL_LIMIT_RST = 24'd1000;
    localparam logic signed [GAIN_W-1:0]  GAIN_P_RST         = 16'sd256;
    localparam logic signed [GAIN_W-1:0]  GAIN_I_RST         = 16'sd0;
    localparam logic signed [GAIN_W-1:0]  GAIN_D_RST         = 16'sd0;
    localparam logic [DUTY_W-1:0]         DUTY_LIMIT_RST     = 15'd1023;
    localparam logic                      MOTORS_ENABLED_RST = 1'b0;

    typedef struct packed {
        logic [RANGE_W-1:0]       angle_range;
        logic [ILIM_W-1:0]        integral_limit;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DUTY_W-1:0]        duty_limit;
        logic                     motors_enabled;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]           channel;
        logic signed [ANGLE_W-1:0] measured_angle;
        logic signed [ANGLE_W-1:0] target_angle;
        logic                      link_connected;
        logic                      link_synced;
    } cmd_t;

    typedef struct packed {
        logic [CH_W-1:0]   out_channel;
        logic              direction;
        logic [DUTY_W-1:0] duty_magnitude;
        logic              pwm_write;
    } rsp_t;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic                    pwm_write;
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
    } err_stage_t;

    typedef struct packed {
        logic [CH_W-1:0]        channel;
        logic                   pwm_write;
        logic signed [PE_W-1:0] p_err;
        logic signed [PI_W-1:0] p_int;
        logic signed [PD_W-1:0] p_der;
    } prod_stage_t;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic                    pwm_write;
        logic signed [SUM_W-1:0] sum;
    } sum_stage_t;

endpackage
`default_nettype wire

>>> hdl/tcpid_error.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpid_error: error, integral and derivative stage
// Clamps the target, forms the error and updates the per-channel integral
// and previous-error state in the cycle an in-range transaction is accepted.
// ----------------------------------------------------------------------------
module tcpid_error #(
    parameter int CHANNELS = tcpid_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcpid_pkg::cfg_t        cfg,
    input  wire logic                   cmd_valid,
    output logic                        cmd_ready,
    input  wire tcpid_pkg::cmd_t        cmd,
    output logic                        stg_valid,
    input  wire logic                   stg_ready,
    output tcpid_pkg::err_stage_t       stg
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [tcpid_pkg::ERR_W-1:0] prev_err_reg [CHANNELS];
    logic signed [tcpid_pkg::INT_W-1:0] integ_reg    [CHANNELS];
    logic                               stg_valid_reg;
    tcpid_pkg::err_stage_t              stg_reg;

    logic [IDX_W-1:0]                    idx;
    logic                                in_range;
    logic                                load;
    logic signed [tcpid_pkg::TARG_W-1:0] half_pos;
    logic signed [tcpid_pkg::TARG_W-1:0] half_neg;
    logic signed [tcpid_pkg::TARG_W-1:0] targ_x;
    logic signed [tcpid_pkg::TARG_W-1:0] targ_c;
    logic signed [tcpid_pkg::ERR_W-1:0]  err_next;
    logic signed [tcpid_pkg::ISUM_W-1:0] isum;
    logic signed [tcpid_pkg::ISUM_W-1:0] ilim_pos;
    logic signed [tcpid_pkg::ISUM_W-1:0] ilim_neg;
    logic signed [tcpid_pkg::INT_W-1:0]  integ_next;
    logic signed [tcpid_pkg::DER_W-1:0]  deriv_next;
    tcpid_pkg::err_stage_t               stg_next;

    assign idx      = IDX_W'(cmd.channel);
    assign in_range = int'(cmd.channel) < CHANNELS;

    assign cmd_ready = !stg_valid_reg || stg_ready;
    assign load      = cmd_valid && cmd_ready && in_range;

    // target clamped to half the angle span
    assign half_pos = signed'({2'b00, cfg.angle_range[tcpid_pkg::RANGE_W-1:1]});
    assign half_neg = -half_pos;
    assign targ_x   = tcpid_pkg::TARG_W'(cmd.target_angle);

    always_comb
    begin
        priority if (targ_x < half_neg)
        begin
            targ_c = half_neg;
        end
        else if (targ_x > half_pos)
        begin
            targ_c = half_pos;
        end
        else
        begin
            targ_c = targ_x;
        end
    end

    assign err_next = tcpid_pkg::ERR_W'(targ_c) - tcpid_pkg::ERR_W'(cmd.measured_angle);

    // integral with symmetric clamp
    assign isum     = tcpid_pkg::ISUM_W'(integ_reg[idx]) + tcpid_pkg::ISUM_W'(err_next);
    assign ilim_pos = signed'({2'b00, cfg.integral_limit});
    assign ilim_neg = -ilim_pos;

    always_comb
    begin
        priority if (isum < ilim_neg)
        begin
            integ_next = tcpid_pkg::INT_W'(ilim_neg);
        end
        else if (isum > ilim_pos)
        begin
            integ_next = tcpid_pkg::INT_W'(ilim_pos);
        end
        else
        begin
            integ_next = tcpid_pkg::INT_W'(isum);
        end
    end

    assign deriv_next = tcpid_pkg::DER_W'(err_next) - tcpid_pkg::DER_W'(prev_err_reg[idx]);

    always_comb
    begin
        stg_next.channel   = cmd.channel;
        stg_next.pwm_write = !cmd.link_connected || cmd.link_synced;
        stg_next.err       = err_next;
        stg_next.integ     = integ_next;
        stg_next.deriv     = deriv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                prev_err_reg[k] <= '0;
                integ_reg[k]    <= '0;
            end
        end
        else
        begin
            if (cmd_ready)
            begin
                stg_valid_reg <= load;
            end
            if (load)
            begin
                prev_err_reg[idx] <= err_next;
                integ_reg[idx]    <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_reg <= stg_next;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

endmodule
`default_nettype wire

>>> hdl/tcpid_mult.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpid_mult: gain multiply stage
// Three parallel signed multiplies of the q8.8 gains by error, integral and
// derivative, each product registered.
// ----------------------------------------------------------------------------
module tcpid_mult (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcpid_pkg::cfg_t        cfg,
    input  wire logic                   src_valid,
    output logic                        src_ready,
    input  wire tcpid_pkg::err_stage_t  src,
    output logic                        stg_valid,
    input  wire logic                   stg_ready,
    output tcpid_pkg::prod_stage_t      stg
);

    logic                   stg_valid_reg;
    tcpid_pkg::prod_stage_t stg_reg;
    tcpid_pkg::prod_stage_t stg_next;
    logic                   load;

    assign src_ready = !stg_valid_reg || stg_ready;
    assign load      = src_valid && src_ready;

    always_comb
    begin
        stg_next.channel   = src.channel;
        stg_next.pwm_write = src.pwm_write;
        stg_next.p_err     = tcpid_pkg::PE_W'(cfg.gain_p) * tcpid_pkg::PE_W'(src.err);
        stg_next.p_int     = tcpid_pkg::PI_W'(cfg.gain_i) * tcpid_pkg::PI_W'(src.integ);
        stg_next.p_der     = tcpid_pkg::PD_W'(cfg.gain_d) * tcpid_pkg::PD_W'(src.deriv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            stg_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_reg <= stg_next;
        end
    end

    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

endmodule
`default_nettype wire

>>> hdl/tcpid_duty.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpid_duty: sum, scale and limit stages
// Adds the three products, then scales by the gain fraction toward zero,
// limits the magnitude and forms direction into the response register.
// ----------------------------------------------------------------------------
module tcpid_duty (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcpid_pkg::cfg_t        cfg,
    input  wire logic                   src_valid,
    output logic                        src_ready,
    input  wire tcpid_pkg::prod_stage_t src,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output tcpid_pkg::rsp_t             rsp
);

    logic                  sum_valid_reg;
    tcpid_pkg::sum_stage_t sum_reg;
    tcpid_pkg::sum_stage_t sum_next;
    logic                  sum_ready;
    logic                  sum_load;

    logic                  rsp_valid_reg;
    tcpid_pkg::rsp_t       rsp_reg;
    tcpid_pkg::rsp_t       rsp_next;
    logic                  rsp_load;

    logic                             neg;
    logic [tcpid_pkg::SUM_W-1:0]      mag;
    logic [tcpid_pkg::SUM_W-1:0]      mag_sh;
    logic [tcpid_pkg::SUM_W-1:0]      lim_x;
    logic [tcpid_pkg::DUTY_W-1:0]     mag_c;

    // handshake chain
    assign rsp_load  = sum_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign sum_ready = !sum_valid_reg || !rsp_valid_reg || rsp_ready;
    assign src_ready = sum_ready;
    assign sum_load  = src_valid && sum_ready;

    always_comb
    begin
        sum_next.channel   = src.channel;
        sum_next.pwm_write = src.pwm_write;
        sum_next.sum       = tcpid_pkg::SUM_W'(src.p_err)
                           + tcpid_pkg::SUM_W'(src.p_int)
                           + tcpid_pkg::SUM_W'(src.p_der);
    end

    // magnitude shift truncates toward zero
    assign neg    = sum_reg.sum[tcpid_pkg::SUM_W-1];
    assign mag    = neg ? unsigned'(-sum_reg.sum) : unsigned'(sum_reg.sum);
    assign mag_sh = mag >> tcpid_pkg::GAIN_FRAC_BITS;
    assign lim_x  = tcpid_pkg::SUM_W'(cfg.duty_limit);
    assign mag_c  = (mag_sh > lim_x) ? cfg.duty_limit : mag_sh[tcpid_pkg::DUTY_W-1:0];

    always_comb
    begin
        rsp_next.out_channel = sum_reg.channel;
        rsp_next.pwm_write   = sum_reg.pwm_write;
        if (cfg.motors_enabled)
        begin
            rsp_next.duty_magnitude = mag_c;
            rsp_next.direction      = !neg && (mag_c != '0);
        end
        else
        begin
            rsp_next.duty_magnitude = '0;
            rsp_next.direction      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_ready)
            begin
                sum_valid_reg <= src_valid;
            end
            if (!rsp_valid_reg || rsp_ready)
            begin
                rsp_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            sum_reg <= sum_next;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

>>> hdl/three_channel_pid_motor_drive_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_channel_pid_motor_drive_top: pid duty controller for three motors
// Per-channel pid with clamped target, clamped integral and limited duty.
// ----------------------------------------------------------------------------
// One command transaction enters per clock while cmd_stall is low and, for a
// channel in range, a response leaves through the error, product, sum and
// response registers; one per cycle is sustained while rsp_stall is low, with
// a read-modify-write of per-channel integral and previous-error state.
// The four stages are error/state update, gain multiply, product sum, and
// scale/limit into the response register; each stage holds its data while
// the next is stalled and frees itself as soon as it is emptied, so
// cmd_stall rises only when every stage is full and rsp_stall is high.
// A command whose channel is not below CHANNELS is taken and dropped: no
// state change and no response. Configuration registers are written through
// cfg_write_en / cfg_index / cfg_data and must only change while no
// transaction is in flight. Channel state clears on reset; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module three_channel_pid_motor_drive_top #(
    parameter int CHANNELS = tcpid_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // command channel
    input  wire logic                              cmd_valid,
    output logic                                   cmd_stall,
    input  wire tcpid_pkg::cmd_t                   cmd_data,

    // response channel
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output tcpid_pkg::rsp_t                        rsp_data,

    // configuration write port
    input  wire logic                              cfg_write_en,
    input  wire logic [tcpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcpid_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    tcpid_pkg::cfg_t cfg_reg;

    // inter-stage handshakes and payloads
    logic                   cmd_ready;
    logic                   err_valid;
    logic                   err_ready;
    tcpid_pkg::err_stage_t  err_stg;
    logic                   prod_valid;
    logic                   prod_ready;
    tcpid_pkg::prod_stage_t prod_stg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_range    <= tcpid_pkg::ANGLE_RANGE_RST;
            cfg_reg.integral_limit <= tcpid_pkg::INTEGRAL_LIMIT_RST;
            cfg_reg.gain_p         <= tcpid_pkg::GAIN_P_RST;
            cfg_reg.gain_i         <= tcpid_pkg::GAIN_I_RST;
            cfg_reg.gain_d         <= tcpid_pkg::GAIN_D_RST;
            cfg_reg.duty_limit     <= tcpid_pkg::DUTY_LIMIT_RST;
            cfg_reg.motors_enabled <= tcpid_pkg::MOTORS_ENABLED_RST;
        end
        else if (cfg_write_en)
        begin
            // writes to unused indexes are dropped
            unique case (cfg_index)
                tcpid_pkg::REG_ANGLE_RANGE:
                    cfg_reg.angle_range <= cfg_data[tcpid_pkg::RANGE_W-1:0];
                tcpid_pkg::REG_INTEGRAL_LIMIT:
                    cfg_reg.integral_limit <= cfg_data[tcpid_pkg::ILIM_W-1:0];
                tcpid_pkg::REG_GAIN_P:
                    cfg_reg.gain_p <= signed'(cfg_data[tcpid_pkg::GAIN_W-1:0]);
                tcpid_pkg::REG_GAIN_I:
                    cfg_reg.gain_i <= signed'(cfg_data[tcpid_pkg::GAIN_W-1:0]);
                tcpid_pkg::REG_GAIN_D:
                    cfg_reg.gain_d <= signed'(cfg_data[tcpid_pkg::GAIN_W-1:0]);
                tcpid_pkg::REG_DUTY_LIMIT:
                    cfg_reg.duty_limit <= cfg_data[tcpid_pkg::DUTY_W-1:0];
                tcpid_pkg::REG_MOTORS_ENABLED:
                    cfg_reg.motors_enabled <= cfg_data[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // stage 1: target clamp, error, integral and derivative with state update
    tcpid_error #(
        .CHANNELS (CHANNELS)
    ) u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd_data),
        .stg_valid (err_valid),
        .stg_ready (err_ready),
        .stg       (err_stg)
    );

    // stage 2: three gain products
    tcpid_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .src_valid (err_valid),
        .src_ready (err_ready),
        .src       (err_stg),
        .stg_valid (prod_valid),
        .stg_ready (prod_ready),
        .stg       (prod_stg)
    );

    // stages 3 and 4: sum, then scale, limit and enable into the response register
    tcpid_duty u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .src_valid (prod_valid),
        .src_ready (prod_ready),
        .src       (prod_stg),
        .rsp_valid (rsp_valid),
        .rsp_ready (!rsp_stall),
        .rsp       (rsp_data)
    );

    assign cmd_stall = !cmd_ready;

endmodule
`default_nettype wire

>>> hdl/tcpid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpid_checker: port-level checks for the pid drive
// Watches the command, response and configuration ports and tracks the
// duty limit and motor enable as written.
// ----------------------------------------------------------------------------
module tcpid_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_stall,
    input  wire logic                              rsp_valid,
    input  wire logic                              rsp_stall,
    input  wire tcpid_pkg::rsp_t                   rsp_data,
    input  wire logic                              cfg_write_en,
    input  wire logic [tcpid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tcpid_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                         enabled_reg;
    logic [tcpid_pkg::DUTY_W-1:0] duty_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= tcpid_pkg::MOTORS_ENABLED_RST;
            duty_limit_reg <= tcpid_pkg::DUTY_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == tcpid_pkg::REG_MOTORS_ENABLED)
            begin
                enabled_reg <= cfg_data[0];
            end
            if (cfg_index == tcpid_pkg::REG_DUTY_LIMIT)
            begin
                duty_limit_reg <= cfg_data[tcpid_pkg::DUTY_W-1:0];
            end
        end
    end

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("response changed while stalled");

    // commands are held back only when the whole pipeline is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (rsp_valid && rsp_stall))
        else $error("command stalled with response side free");

    // forward direction needs a nonzero duty
    a_dir_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.direction) |-> (rsp_data.duty_magnitude != '0))
        else $error("direction set with zero duty");

    // motors off forces zero duty
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !enabled_reg) |->
            (rsp_data.duty_magnitude == '0 && !rsp_data.direction))
        else $error("duty driven while motors disabled");

    // duty stays within the written limit
    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.duty_magnitude <= duty_limit_reg))
        else $error("duty above limit");

endmodule

bind three_channel_pid_motor_drive_top tcpid_checker u_tcpid_checker (.*);
`default_nettype wire
